// ----- hw/rtl/rea_pkg.sv -----
// ----------------------------------------------------------------------------
// rea_pkg
// shared types and codes for the relative error accumulator
// ----------------------------------------------------------------------------
package rea_pkg;

   localparam int FIELD_W = 32;
   localparam int MAG_W   = 31;

   // request commands
   typedef enum logic [1:0] {
      CMD_SAMPLE  = 2'd0,
      CMD_REPORT  = 2'd1,
      CMD_RESTART = 2'd2
   } cmd_type;

   // error modes
   typedef enum logic {
      MODE_RMS  = 1'b0,
      MODE_MEAN = 1'b1
   } error_mode_type;

   // register indexes
   typedef enum logic [1:0] {
      REG_ERROR_MODE        = 2'd0,
      REG_MAGNITUDE_MIN     = 2'd1,
      REG_MAGNITUDE_MAX     = 2'd2,
      REG_DENOMINATOR_FLOOR = 2'd3
   } reg_index_type;

   // sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_RANGE,
      ST_SAMPLE_DIV,
      ST_SQUARE,
      ST_ACCUM,
      ST_MEAN_DIV,
      ST_ROOT_PREP,
      ST_ROOT,
      ST_RESULT
   } state_type;

   typedef struct packed {
      cmd_type                    cmd;
      logic signed [FIELD_W-1:0]  measured;
      logic signed [FIELD_W-1:0]  compared;
      logic                       in_window;
   } req_payload_type;

   typedef struct packed {
      logic [FIELD_W-1:0] result_value;
      logic               no_points;
      logic [FIELD_W-1:0] accepted_count;
   } rsp_payload_type;

   typedef struct packed {
      reg_index_type      index;
      logic [FIELD_W-1:0] data;
   } csr_payload_type;

   typedef struct packed {
      error_mode_type   error_mode;
      logic [MAG_W-1:0] magnitude_min;
      logic [MAG_W-1:0] magnitude_max;
      logic [MAG_W-1:0] denominator_floor;
   } cfg_type;

endpackage

// ----- hw/rtl/rea_stream_if.sv -----
// ----------------------------------------------------------------------------
// rea_stream_if
// valid/ready channel carrying one payload
// ----------------------------------------------------------------------------
interface rea_stream_if #(
   parameter type payload_type = logic
) ();

   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);

endinterface

// ----- hw/rtl/rea_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// rea_cfg_regs
// configuration register bank written over the csr channel
// ----------------------------------------------------------------------------
module rea_cfg_regs
   import rea_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   rea_stream_if.sink csr_ch,
   output cfg_type cfg
);

   cfg_type cfg_ff, cfg_in;
   logic    wr_fire;

   assign csr_ch.ready = 1'b1;
   assign wr_fire      = csr_ch.valid && csr_ch.ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_fire) begin
         unique case (csr_ch.payload.index)
            REG_ERROR_MODE: begin
               cfg_in.error_mode = error_mode_type'(csr_ch.payload.data[0]);
            end
            REG_MAGNITUDE_MIN: begin
               cfg_in.magnitude_min = csr_ch.payload.data[MAG_W-1:0];
            end
            REG_MAGNITUDE_MAX: begin
               cfg_in.magnitude_max = csr_ch.payload.data[MAG_W-1:0];
            end
            REG_DENOMINATOR_FLOOR: begin
               cfg_in.denominator_floor = csr_ch.payload.data[MAG_W-1:0];
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.error_mode        <= MODE_RMS;
         cfg_ff.magnitude_min     <= '0;
         cfg_ff.magnitude_max     <= '1;
         cfg_ff.denominator_floor <= MAG_W'(1);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- hw/rtl/rea_cmp_sub.sv -----
// ----------------------------------------------------------------------------
// rea_cmp_sub
// shared compare and subtract step for division and square root
// ----------------------------------------------------------------------------
module rea_cmp_sub #(
   parameter int WIDTH = 35
) (
   input  logic [WIDTH-1:0] minuend,
   input  logic [WIDTH-1:0] subtrahend,
   output logic [WIDTH-1:0] difference,
   output logic             no_borrow
);

   logic [WIDTH:0] wide_diff;

   assign wide_diff  = {1'b0, minuend} - {1'b0, subtrahend};
   assign difference = wide_diff[WIDTH-1:0];
   assign no_borrow  = ~wide_diff[WIDTH];

endmodule

// ----- hw/rtl/relative_error_accumulator.sv -----
// ----------------------------------------------------------------------------
// relative_error_accumulator: one request at a time, ready only when idle
// sample: check, then if accepted range, ratio division, square, accumulate
// report: mean division, plus the square root in rms mode
// restart clears sum and count; synchronous reset clears sum, count and registers
// ----------------------------------------------------------------------------
module relative_error_accumulator
   import rea_pkg::*;
#(
   parameter int DATA_WIDTH  = 32,
   parameter int COUNT_WIDTH = 32
) (
   input  logic clock,
   input  logic reset,
   rea_stream_if.sink   req_ch,
   rea_stream_if.source rsp_ch,
   rea_stream_if.sink   csr_ch
);

   // ratio and result width, and the limit both saturate to
   localparam int RES_W = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
   localparam logic [63:0] RES_LIMIT = (64'd1 << RES_W) - 64'd1;
   // remainder width of the shared unit: mean division or square root
   localparam int SUB_W  = (COUNT_WIDTH + 1 > 35) ? COUNT_WIDTH + 1 : 35;
   localparam int STEP_W = 7;

   // sequencer
   state_type state_ff, state_in;
   logic      req_ready;
   logic      req_fire;
   logic      rsp_load;

   cfg_type   cfg;

   // sample operands
   logic [31:0]        mag_ff, mag_in;
   logic [32:0]        dsgn_ff, dsgn_in;
   logic               win_ff, win_in;
   logic [MAG_W-1:0]   den_ff, den_in;
   logic [32:0]        diff_ff, diff_in;

   // shared iteration registers
   logic [SUB_W-1:0]   rem_ff, rem_in;
   logic [SUB_W-1:0]   divisor_ff, divisor_in;
   logic [63:0]        quo_ff, quo_in;
   logic [31:0]        root_ff, root_in;
   logic [STEP_W-1:0]  step_ff, step_in;

   // accumulation
   logic [RES_W-1:0]   ratio_ff, ratio_in;
   logic [63:0]        addend_ff, addend_in;
   logic [63:0]        sum_ff, sum_in;
   logic [COUNT_WIDTH-1:0] cnt_ff, cnt_in;

   // result
   logic [31:0]        res_ff, res_in;
   logic               nop_ff, nop_in;
   rsp_payload_type    rsp_pl_ff, rsp_pl_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // combinational helpers
   logic [31:0]        meas_u;
   logic [MAG_W-1:0]   floor_eff;
   logic               sample_ok;
   logic [MAG_W-1:0]   den_sel;
   logic [32:0]        diff_abs;
   logic [48:0]        num;
   logic [48:0]        num_hi;
   logic               ratio_ovf;
   logic [SUB_W-1:0]   trial_div, trial_sqrt, sub_sqrt;
   logic [SUB_W-1:0]   unit_a, unit_b, unit_diff;
   logic               unit_ge;
   logic               last_step;
   logic               mean_big;
   logic [31:0]        root_next;
   logic [2*RES_W-1:0] ratio_sq;
   logic [64:0]        sum_wide;
   logic [63:0]        cnt_wide;

   rea_cfg_regs u_cfg_regs (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .cfg    (cfg)
   );

   // the one compare and subtract unit, shared by every division and root step
   rea_cmp_sub #(
      .WIDTH (SUB_W)
   ) u_cmp_sub (
      .minuend    (unit_a),
      .subtrahend (unit_b),
      .difference (unit_diff),
      .no_borrow  (unit_ge)
   );

   assign req_fire = req_ch.valid && req_ready;

   // magnitude and signed difference of the incoming pair
   assign meas_u  = req_ch.payload.measured;
   assign mag_in  = meas_u[31] ? (~meas_u + 32'd1) : meas_u;
   assign dsgn_in = {req_ch.payload.measured[31], req_ch.payload.measured}
                  - {req_ch.payload.compared[31], req_ch.payload.compared};
   assign win_in  = req_ch.payload.in_window;

   // window test and denominator; a zero floor acts as one lsb
   assign floor_eff = (cfg.denominator_floor == '0) ? MAG_W'(1) : cfg.denominator_floor;
   assign sample_ok = win_ff
                   && (mag_ff >= {1'b0, cfg.magnitude_min})
                   && (mag_ff <= {1'b0, cfg.magnitude_max});
   assign den_sel   = (mag_ff > {1'b0, floor_eff}) ? mag_ff[MAG_W-1:0] : floor_eff;
   assign diff_abs  = dsgn_ff[32] ? (~dsgn_ff + 33'd1) : dsgn_ff;

   // ratio overflows when the quotient would need more than RES_W bits
   assign num       = {diff_ff, 16'b0};
   assign num_hi    = num >> RES_W;
   assign ratio_ovf = (num_hi >= 49'(den_ff));

   // operand selection for the shared unit
   assign trial_div  = {rem_ff[SUB_W-2:0], quo_ff[63]};
   assign trial_sqrt = {rem_ff[SUB_W-3:0], quo_ff[63:62]};
   assign sub_sqrt   = SUB_W'({root_ff, 2'b01});
   assign unit_a     = (state_ff == ST_ROOT) ? trial_sqrt : trial_div;
   assign unit_b     = (state_ff == ST_ROOT) ? sub_sqrt : divisor_ff;

   assign last_step = (step_ff == STEP_W'(1));
   assign mean_big  = |quo_ff[63:48];
   assign root_next = {root_ff[30:0], unit_ge};
   assign ratio_sq  = ratio_ff * ratio_ff;
   assign sum_wide  = {1'b0, sum_ff} + {1'b0, addend_ff};
   assign cnt_wide  = 64'(cnt_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               unique case (req_ch.payload.cmd)
                  CMD_SAMPLE: state_in = ST_CHECK;
                  CMD_REPORT: state_in = (cnt_ff == '0) ? ST_RESULT : ST_MEAN_DIV;
                  default:    state_in = ST_IDLE;
               endcase
            end
         end
         ST_CHECK:      state_in = sample_ok ? ST_RANGE : ST_IDLE;
         ST_RANGE:      state_in = ratio_ovf ? ST_SQUARE : ST_SAMPLE_DIV;
         ST_SAMPLE_DIV: state_in = last_step ? ST_SQUARE : ST_SAMPLE_DIV;
         ST_SQUARE:     state_in = ST_ACCUM;
         ST_ACCUM:      state_in = ST_IDLE;
         ST_MEAN_DIV:   state_in = last_step ? ST_ROOT_PREP : ST_MEAN_DIV;
         ST_ROOT_PREP: begin
            if ((cfg.error_mode == MODE_MEAN) || mean_big) begin
               state_in = ST_RESULT;
            end else begin
               state_in = ST_ROOT;
            end
         end
         ST_ROOT:       state_in = last_step ? ST_RESULT : ST_ROOT;
         ST_RESULT:     state_in = rsp_load ? ST_IDLE : ST_RESULT;
         default:       state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_ready = (state_ff == ST_IDLE);
      rsp_load  = (state_ff == ST_RESULT) && (!rsp_valid_ff || rsp_ch.ready);
   end

   // datapath next values
   always_comb begin
      den_in     = den_ff;
      diff_in    = diff_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      quo_in     = quo_ff;
      root_in    = root_ff;
      step_in    = step_ff;
      ratio_in   = ratio_ff;
      addend_in  = addend_ff;
      sum_in     = sum_ff;
      cnt_in     = cnt_ff;
      res_in     = res_ff;
      nop_in     = nop_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               unique case (req_ch.payload.cmd)
                  CMD_REPORT: begin
                     // load sum / count into the divider
                     res_in     = '0;
                     nop_in     = (cnt_ff == '0);
                     rem_in     = '0;
                     quo_in     = sum_ff;
                     divisor_in = SUB_W'(cnt_ff);
                     step_in    = STEP_W'(64);
                  end
                  CMD_RESTART: begin
                     sum_in = '0;
                     cnt_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_CHECK: begin
            den_in  = den_sel;
            diff_in = diff_abs;
         end
         ST_RANGE: begin
            if (ratio_ovf) begin
               ratio_in = '1;
            end else begin
               // high part is below the divisor, low part shifts in bit by bit
               rem_in     = SUB_W'(num_hi[MAG_W-1:0]);
               quo_in     = {num[RES_W-1:0], {(64-RES_W){1'b0}}};
               divisor_in = SUB_W'(den_ff);
               step_in    = STEP_W'(RES_W);
            end
         end
         ST_SAMPLE_DIV, ST_MEAN_DIV: begin
            rem_in  = unit_ge ? unit_diff : unit_a;
            quo_in  = {quo_ff[62:0], unit_ge};
            step_in = step_ff - STEP_W'(1);
            if (last_step) begin
               ratio_in = {quo_ff[RES_W-2:0], unit_ge};
            end
         end
         ST_SQUARE: begin
            if (cfg.error_mode == MODE_MEAN) begin
               addend_in = 64'(ratio_ff);
            end else begin
               addend_in = 64'(ratio_sq >> 16);
            end
         end
         ST_ACCUM: begin
            sum_in = sum_wide[64] ? '1 : sum_wide[63:0];
            cnt_in = (cnt_ff == '1) ? cnt_ff : cnt_ff + COUNT_WIDTH'(1);
         end
         ST_ROOT_PREP: begin
            if (cfg.error_mode == MODE_MEAN) begin
               res_in = (quo_ff > RES_LIMIT) ? RES_LIMIT[31:0] : quo_ff[31:0];
            end else if (mean_big) begin
               res_in = RES_LIMIT[31:0];
            end else begin
               // root of mean in q16.16 is the root of mean shifted by 16
               quo_in  = {quo_ff[47:0], 16'b0};
               rem_in  = '0;
               root_in = '0;
               step_in = STEP_W'(32);
            end
         end
         ST_ROOT: begin
            rem_in  = unit_ge ? unit_diff : unit_a;
            root_in = root_next;
            quo_in  = {quo_ff[61:0], 2'b00};
            step_in = step_ff - STEP_W'(1);
            if (last_step) begin
               res_in = (root_next > RES_LIMIT[31:0]) ? RES_LIMIT[31:0] : root_next;
            end
         end
         ST_RESULT: begin
         end
         default: begin
         end
      endcase
   end

   // output register
   always_comb begin
      rsp_pl_in = rsp_pl_ff;
      if (rsp_load) begin
         rsp_pl_in.result_value   = res_ff;
         rsp_pl_in.no_points      = nop_ff;
         rsp_pl_in.accepted_count = (cnt_wide > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF
                                                              : cnt_wide[31:0];
      end
      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ch.ready);
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sum_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         mag_ff  <= mag_in;
         dsgn_ff <= dsgn_in;
         win_ff  <= win_in;
      end
      den_ff     <= den_in;
      diff_ff    <= diff_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
      quo_ff     <= quo_in;
      root_ff    <= root_in;
      step_ff    <= step_in;
      ratio_ff   <= ratio_in;
      addend_ff  <= addend_in;
      res_ff     <= res_in;
      nop_ff     <= nop_in;
      rsp_pl_ff  <= rsp_pl_in;
   end

   assign req_ch.ready   = req_ready;
   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.payload = rsp_pl_ff;

`ifndef SYNTHESIS
   // a new response only comes out of the result state
   a_rsp_from_result: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_ch.valid) |-> $past(state_ff == ST_RESULT))
      else $error("response raised outside result state");

   // iterating states always have steps left
   a_step_live: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SAMPLE_DIV || state_ff == ST_MEAN_DIV || state_ff == ST_ROOT)
      |-> (step_ff != '0))
      else $error("iteration with zero steps left");

   // the count moves only on accumulation or a request
   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_ACCUM && !req_fire) |=> $stable(cnt_ff))
      else $error("point count changed unexpectedly");

   // an empty report carries zero result and zero count
   a_empty_report: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.payload.no_points)
      |-> (rsp_ch.payload.result_value == '0 && rsp_ch.payload.accepted_count == '0))
      else $error("empty report with non-zero fields");
`endif

endmodule
